@@ rtl/usc_pkg.sv @@
// ----------------------------------------------------------------------------
// usc_pkg
// Shared constants and the month start table for the seconds-to-calendar
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package usc_pkg;

  // pipeline depth from input register to output register
  localparam int unsigned NumStages = 8;

  // seconds per day is 128 * 675; the low 7 bits pass straight through
  localparam int unsigned SecLoBits = 7;
  localparam logic [9:0]  DayDivisor = 10'd675;
  // floor(2^32 / 675), estimate is exact or one low
  localparam logic [22:0] DayRecip = 23'd6362914;

  // ceil(2^29 / 3600), exact for any second of day
  localparam logic [17:0] HourRecip  = 18'd149131;
  localparam logic [11:0] SecPerHour = 12'd3600;
  // ceil(2^18 / 60), exact for any second of hour
  localparam logic [12:0] MinRecip  = 13'd4370;
  localparam logic [5:0]  SecPerMin = 6'd60;

  // day count rebased to 1968-01-01, the start of a four year cycle
  localparam logic [15:0] EpochOffset = 16'd731;
  // day index of 2100-03-01 from 1970; a phantom 2100-02-29 is inserted here
  localparam logic [15:0] Gap2100 = 16'd47541;
  // ceil(2^26 / 1461), exact for any rebased day count
  localparam logic [15:0] CycleRecip = 16'd45934;
  localparam logic [10:0] CycleDays  = 11'd1461;
  localparam logic [11:0] BaseYear   = 12'd1968;

  // start of years one to three within a four year cycle
  localparam logic [10:0] Year1Start = 11'd366;
  localparam logic [10:0] Year2Start = 11'd731;
  localparam logic [10:0] Year3Start = 11'd1096;

  localparam int unsigned MonthsPerYear = 12;

  // day of year on which a month starts, month index from 0
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
    logic [8:0] base;
    logic [8:0] adj;
    unique case (mon)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    adj = (leap && (mon >= 4'd2)) ? 9'd1 : 9'd0;
    return base + adj;
  endfunction

endpackage

`default_nettype wire

@@ rtl/usc_day_split.sv @@
// ----------------------------------------------------------------------------
// usc_day_split
// Splits the seconds count into whole days and second of day over three
// stages: reciprocal multiply, back multiply, remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module usc_day_split (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] unix_seconds_i,
  output logic      [15:0] day_o,
  output logic      [16:0] sod_o
);

  // stage 1 signals
  logic [24:0] x1_d, x1_q;
  logic [6:0]  lo1_d, lo1_q;
  logic [47:0] prod1_d, prod1_q;
  // stage 2 signals
  logic [15:0] q2_d, q2_q;
  logic [24:0] t2_d, t2_q;
  logic [24:0] x2_q;
  logic [6:0]  lo2_q;
  // stage 3 signals
  logic [24:0] diff3;
  logic [10:0] rem3;
  logic        corr3;
  logic [9:0]  remf3;
  logic [15:0] day3_d, day3_q;
  logic [16:0] sod3_d, sod3_q;

  // stage 1: shift out the factor of 128, estimate quotient by 675
  always_comb begin
    x1_d    = unix_seconds_i[31:usc_pkg::SecLoBits];
    lo1_d   = unix_seconds_i[usc_pkg::SecLoBits-1:0];
    prod1_d = 48'(x1_d) * 48'(usc_pkg::DayRecip);
  end

  // stage 2: quotient estimate and its multiple of 675
  always_comb begin
    q2_d = prod1_q[47:32];
    t2_d = 25'(26'(q2_d) * 26'(usc_pkg::DayDivisor));
  end

  // stage 3: remainder, fix the estimate when it was one low
  always_comb begin
    diff3  = x2_q - t2_q;
    rem3   = diff3[10:0];
    corr3  = (rem3 >= 11'(usc_pkg::DayDivisor));
    remf3  = corr3 ? 10'(rem3 - 11'(usc_pkg::DayDivisor)) : rem3[9:0];
    day3_d = q2_q + 16'(corr3);
    sod3_d = {remf3, lo2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= x1_d;
      lo1_q   <= lo1_d;
      prod1_q <= prod1_d;
      q2_q    <= q2_d;
      t2_q    <= t2_d;
      x2_q    <= x1_q;
      lo2_q   <= lo1_q;
      day3_q  <= day3_d;
      sod3_q  <= sod3_d;
    end
  end

  assign day_o = day3_q;
  assign sod_o = sod3_q;

endmodule

`default_nettype wire

@@ rtl/usc_tod.sv @@
// ----------------------------------------------------------------------------
// usc_tod
// Breaks the second of day into hour, minute and second over five stages,
// each division done as a reciprocal multiply followed by a back multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module usc_tod (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [16:0] sod_i,
  output logic      [4:0]  hour_o,
  output logic      [5:0]  minute_o,
  output logic      [5:0]  second_o
);

  logic [33:0] hp4_d, hp4_q;
  logic [16:0] sod4_q;
  logic [4:0]  hr5_d, hr5_q;
  logic [16:0] th5_d, th5_q;
  logic [16:0] sod5_q;
  logic [16:0] sohw6;
  logic [11:0] soh6_d, soh6_q;
  logic [23:0] mp6_d, mp6_q;
  logic [4:0]  hr6_q;
  logic [5:0]  mn7_d, mn7_q;
  logic [11:0] tm7;
  logic [11:0] scw7;
  logic [5:0]  sc7_d, sc7_q;
  logic [4:0]  hr7_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  // stage 4: hour estimate product
  assign hp4_d = 34'(35'(sod_i) * 35'(usc_pkg::HourRecip));

  // stage 5: hour and its seconds
  always_comb begin
    hr5_d = hp4_q[33:29];
    th5_d = 17'(hr5_d) * 17'(usc_pkg::SecPerHour);
  end

  // stage 6: second of hour and minute estimate product
  always_comb begin
    sohw6  = sod5_q - th5_q;
    soh6_d = sohw6[11:0];
    mp6_d  = 24'(25'(soh6_d) * 25'(usc_pkg::MinRecip));
  end

  // stage 7: minute and second of minute
  always_comb begin
    mn7_d = mp6_q[23:18];
    tm7   = 12'(mn7_d) * 12'(usc_pkg::SecPerMin);
    scw7  = soh6_q - tm7;
    sc7_d = scw7[5:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hp4_q    <= hp4_d;
      sod4_q   <= sod_i;
      hr5_q    <= hr5_d;
      th5_q    <= th5_d;
      sod5_q   <= sod4_q;
      hr6_q    <= hr5_q;
      soh6_q   <= soh6_d;
      mp6_q    <= mp6_d;
      hr7_q    <= hr6_q;
      mn7_q    <= mn7_d;
      sc7_q    <= sc7_d;
      // stage 8: output register, lines up with the date branch
      hour_q   <= hr7_q;
      minute_q <= mn7_q;
      second_q <= sc7_q;
    end
  end

  assign hour_o   = hour_q;
  assign minute_o = minute_q;
  assign second_o = second_q;

endmodule

`default_nettype wire

@@ rtl/usc_date.sv @@
// ----------------------------------------------------------------------------
// usc_date
// Turns a day count since 1970 into year, month and day over five stages.
// The count is rebased to 1968 and a phantom 2100-02-29 is inserted, so
// every fourth year is leap across the whole input range.
// ----------------------------------------------------------------------------
`default_nettype none

module usc_date (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] day_i,
  output logic      [11:0] year_o,
  output logic      [3:0]  month_o,
  output logic      [4:0]  day_o
);

  logic [15:0] dpp4_d, dpp4_q;
  logic [31:0] prc4_d, prc4_q;
  logic [5:0]  c5_d, c5_q;
  logic [15:0] t5_d, t5_q;
  logic [15:0] dpp5_q;
  logic [15:0] rw6;
  logic [10:0] r6;
  logic [1:0]  yc6;
  logic [10:0] ys6;
  logic [11:0] year6_d, year6_q;
  logic [8:0]  doy6_d, doy6_q;
  logic        leap6_d, leap6_q;
  logic [3:0]  mon7_d, mon7_q;
  logic [11:0] year7_q;
  logic [8:0]  doy7_q;
  logic        leap7_q;
  logic [8:0]  dom8;
  logic [4:0]  day8_d;
  logic [3:0]  month8_d;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;

  // stage 4: rebase, skip the missing leap day of 2100, cycle estimate
  always_comb begin
    dpp4_d = day_i + usc_pkg::EpochOffset + 16'(day_i >= usc_pkg::Gap2100);
    prc4_d = 32'(dpp4_d) * 32'(usc_pkg::CycleRecip);
  end

  // stage 5: four year cycle index and its first day
  always_comb begin
    c5_d = prc4_q[31:26];
    t5_d = 16'(17'(c5_d) * 17'(usc_pkg::CycleDays));
  end

  // stage 6: year within the cycle and day of year
  always_comb begin
    rw6 = dpp5_q - t5_q;
    r6  = rw6[10:0];
    priority if (r6 < usc_pkg::Year1Start) begin
      yc6 = 2'd0;
      ys6 = 11'd0;
    end else if (r6 < usc_pkg::Year2Start) begin
      yc6 = 2'd1;
      ys6 = usc_pkg::Year1Start;
    end else if (r6 < usc_pkg::Year3Start) begin
      yc6 = 2'd2;
      ys6 = usc_pkg::Year2Start;
    end else begin
      yc6 = 2'd3;
      ys6 = usc_pkg::Year3Start;
    end
    doy6_d  = 9'(r6 - ys6);
    leap6_d = (yc6 == 2'd0);
    year6_d = usc_pkg::BaseYear + {4'd0, c5_q, 2'b00} + 12'(yc6);
  end

  // stage 7: month search over the start table
  always_comb begin
    mon7_d = 4'd0;
    for (int i = 1; i < usc_pkg::MonthsPerYear; i++) begin
      if (doy6_q >= usc_pkg::month_start(leap6_q, 4'(i))) begin
        mon7_d = 4'(i);
      end
    end
  end

  // stage 8: day of month and one based month
  always_comb begin
    dom8     = doy7_q - usc_pkg::month_start(leap7_q, mon7_q) + 9'd1;
    day8_d   = dom8[4:0];
    month8_d = mon7_q + 4'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dpp4_q  <= dpp4_d;
      prc4_q  <= prc4_d;
      c5_q    <= c5_d;
      t5_q    <= t5_d;
      dpp5_q  <= dpp4_q;
      year6_q <= year6_d;
      doy6_q  <= doy6_d;
      leap6_q <= leap6_d;
      mon7_q  <= mon7_d;
      year7_q <= year6_q;
      doy7_q  <= doy6_q;
      leap7_q <= leap6_q;
      year_q  <= year7_q;
      month_q <= month8_d;
      day_q   <= day8_d;
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

`default_nettype wire

@@ rtl/unix_seconds_to_calendar.sv @@
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar: unsigned seconds since 1970 to UTC date and time
// Three stages of day split are followed by five stages in the date and
// time of day branches, from input transaction to output valid.
// Throughput: one transaction per cycle; the whole pipe holds only while
// the output register is full and not taken.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_seconds_to_calendar (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] unix_seconds_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [11:0] year_o,
  output logic      [3:0]  month_o,
  output logic      [4:0]  day_o,
  output logic      [4:0]  hour_o,
  output logic      [5:0]  minute_o,
  output logic      [5:0]  second_o
);

  logic                           en;
  logic [usc_pkg::NumStages-1:0] valid_d, valid_q;
  logic [15:0]                    day_cnt;
  logic [16:0]                    sod;

  // pipe advances unless a finished transaction waits at the output
  assign en         = ~valid_q[usc_pkg::NumStages-1] | out_ready_i;
  assign in_ready_o = en;
  assign valid_d    = {valid_q[usc_pkg::NumStages-2:0], in_valid_i};

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // days and second of day
  usc_day_split u_day_split (
    .clk_i          (clk_i),
    .en_i           (en),
    .unix_seconds_i (unix_seconds_i),
    .day_o          (day_cnt),
    .sod_o          (sod)
  );

  // calendar date branch
  usc_date u_date (
    .clk_i   (clk_i),
    .en_i    (en),
    .day_i   (day_cnt),
    .year_o  (year_o),
    .month_o (month_o),
    .day_o   (day_o)
  );

  // time of day branch
  usc_tod u_tod (
    .clk_i    (clk_i),
    .en_i     (en),
    .sod_i    (sod),
    .hour_o   (hour_o),
    .minute_o (minute_o),
    .second_o (second_o)
  );

  assign out_valid_o = valid_q[usc_pkg::NumStages-1];

`ifndef SYNTHESIS
  // input stalls only behind a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked output");

  // a blocked output transaction keeps its fields
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(year_o) && $stable(month_o) &&
      $stable(day_o) && $stable(hour_o) && $stable(minute_o) && $stable(second_o)))
    else $error("output fields changed while stalled");

  // date fields in range
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (year_o >= 12'd1970 && year_o <= 12'd2106 &&
      month_o >= 4'd1 && month_o <= 4'd12 && day_o >= 5'd1 &&
      (month_o != 4'd2 || day_o <= 5'd29)))
    else $error("date field out of range");

  // time fields in range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59))
    else $error("time field out of range");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for unix_seconds_to_calendar
// Drives 32-bit unix timestamps through the valid/ready input channel and
// checks every date and time transaction on the output channel against an
// in-bench calendar calculation. Directed timestamps cover the epoch, the
// largest count, leap days and the skipped leap day of 2100. Random
// timestamps follow, in three phases with different idle patterns on each
// side, plus one long output stall.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned SecPerDay   = 86400;
  localparam int unsigned MaxSeconds  = 32'hFFFF_FFFF;
  localparam int unsigned RandPerPhase = 476;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_date_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic [31:0] unix_seconds_i = '0;
  logic        out_ready_i    = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;

  logic [31:0]  pending_stamps[$];
  cal_date_t    expected_dates[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  src_idle_pct   = 0;
  int unsigned  snk_idle_pct   = 0;
  int           phase_idx      = -1;
  logic         rx_hold        = 1'b0;

  unix_seconds_to_calendar uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .unix_seconds_i (unix_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_o          (day_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // gregorian leap rule
  function automatic bit leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // month length, month index from 0
  function automatic int unsigned month_length(input bit leap, input int unsigned mon);
    case (mon)
      1:             return leap ? 29 : 28;
      3, 5, 8, 10:   return 30;
      default:       return 31;
    endcase
  endfunction

  // timestamp to calendar date, peeling off years then months
  function automatic cal_date_t calendar_of(input logic [31:0] secs);
    int unsigned days;
    int unsigned sod;
    int unsigned yr;
    int unsigned mon;
    int unsigned ylen;
    bit          leap;
    cal_date_t   res;
    days = secs / SecPerDay;
    sod  = secs % SecPerDay;
    yr   = 1970;
    leap = leap_year(yr);
    ylen = leap ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      leap = leap_year(yr);
      ylen = leap ? 366 : 365;
    end
    mon = 0;
    while (mon < 11 && days >= month_length(leap, mon)) begin
      days -= month_length(leap, mon);
      mon++;
    end
    res.year   = yr[11:0];
    res.month  = 4'(mon + 1);
    res.day    = 5'(days + 1);
    res.hour   = 5'(sod / 3600);
    res.minute = 6'((sod % 3600) / 60);
    res.second = 6'(sod % 60);
    return res;
  endfunction

  // random timestamp, biased toward day edges
  function automatic logic [31:0] random_stamp();
    longint unsigned stamp;
    int unsigned     pick;
    pick = $urandom_range(9);
    if (pick < 5) begin
      return $urandom;
    end
    stamp = longint'($urandom_range(49710)) * SecPerDay;
    if (pick < 7) begin
      stamp += (pick == 5) ? 0 : SecPerDay - 1;
    end else begin
      stamp += $urandom_range(SecPerDay - 1);
    end
    if (stamp > MaxSeconds) begin
      stamp = MaxSeconds;
    end
    return stamp[31:0];
  endfunction

  // report one field mismatch
  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // driver: offers pending timestamps, records expected dates on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      unix_seconds_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_dates.push_back(calendar_of(unix_seconds_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_stamps.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid_i     <= 1'b1;
          unix_seconds_i <= pending_stamps.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each output transaction with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    cal_date_t exp_d;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                   $time, year_o, month_o, day_o, hour_o, minute_o, second_o);
          mismatch_count++;
        end else begin
          exp_d = expected_dates.pop_front();
          check_field("year",   exp_d.year,   year_o);
          check_field("month",  exp_d.month,  month_o);
          check_field("day",    exp_d.day,    day_o);
          check_field("hour",   exp_d.hour,   hour_o);
          check_field("minute", exp_d.minute, minute_o);
          check_field("second", exp_d.second, second_o);
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // long output stall in the last phase so the pipe fills and backs up
  initial begin
    wait (phase_idx == 2);
    repeat (20) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 3; p++) begin
      // sender waits until every expected date has come back
      while (pending_stamps.size() != 0 || in_valid_i || expected_dates.size() != 0) begin
        @(posedge clk_i);
      end
      @(posedge clk_i);
      case (p)
        0: begin
          src_idle_pct <= 7;
          snk_idle_pct <= 85;
        end
        1: begin
          src_idle_pct <= 85;
          snk_idle_pct <= 7;
        end
        default: begin
          src_idle_pct <= 0;
          snk_idle_pct <= 0;
        end
      endcase
      phase_idx <= p;
      if (p == 0) begin
        // epoch and first boundaries of the day
        pending_stamps.push_back(32'd0);
        pending_stamps.push_back(32'd59);
        pending_stamps.push_back(32'd60);
        pending_stamps.push_back(32'd3599);
        pending_stamps.push_back(32'd3600);
        pending_stamps.push_back(32'd86399);
        pending_stamps.push_back(32'd86400);
        // end of first year, leap day 1972, the day after and the end of 1972
        pending_stamps.push_back(32'd31535999);
        pending_stamps.push_back(32'd68169600);
        pending_stamps.push_back(32'd68256000);
        pending_stamps.push_back(32'd94694399);
        // leap day of 2000, a century leap year, and its year end
        pending_stamps.push_back(32'd951782400);
        pending_stamps.push_back(32'd951868799);
        pending_stamps.push_back(32'd978307199);
        // largest signed count, alternating bit patterns
        pending_stamps.push_back(32'h7FFF_FFFF);
        pending_stamps.push_back(32'h8000_0000);
        pending_stamps.push_back(32'hAAAA_AAAA);
        pending_stamps.push_back(32'h5555_5555);
        // 2100 is not leap: end of february straight into march
        pending_stamps.push_back(32'd4107542399);
        pending_stamps.push_back(32'd4107542400);
        // start of the last, partial day and the largest count
        pending_stamps.push_back(32'd4294944000);
        pending_stamps.push_back(32'hFFFF_FFFF);
      end
      for (int i = 0; i < RandPerPhase; i++) begin
        pending_stamps.push_back(random_stamp());
      end
    end

    // drain, then keep clocking to catch stray transactions
    while (pending_stamps.size() != 0 || in_valid_i || expected_dates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (usc_pkg::NumStages + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/usc_pkg.sv
rtl/usc_day_split.sv
rtl/usc_tod.sv
rtl/usc_date.sv
rtl/unix_seconds_to_calendar.sv
tb/tb_top.sv
